// ----- rtl/core/nnta_pkg.sv -----
package nnta_pkg;

    localparam int COORD_W   = 12;
    localparam int DIST_W    = 25;
    localparam int TIDX_W    = 4;
    localparam int OUTCOME_W = 2;
    localparam int HLEN_W    = 5;

    localparam logic [DIST_W-1:0] THR_RESET = 25'd2500;

    localparam logic [OUTCOME_W-1:0] OUTCOME_MATCH = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NEW   = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_DROP  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic              busy;
        logic              found;
        logic [DIST_W-1:0] best_dist;
    } scan_status_t;

endpackage

// ----- rtl/core/nearest_neighbor_track_associator.sv -----
// Nearest-neighbor track associator. Each detection (s_tdata, frame end on s_tlast)
// produces one result (m_tdata, frame_done on m_tlast). The track slots sit in a
// one-read-port memory that is swept one slot per cycle through a three-stage
// distance pipeline before the decision; one detection is in work at a time, and
// the next is taken as soon as the previous result is in the output register.
// The threshold register may be written only between detections.
module nearest_neighbor_track_associator #(
    parameter int MAX_TRACKS = 16,
    parameter int HIST_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // det_x[11:0], det_y[23:12]
    input  logic        s_tlast,   // last_in_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // track_index[3:0], outcome[5:4], history_length[10:6]
    output logic        m_tlast,   // frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data   // dist_sq_threshold
);

    localparam int CRW  = nnta_pkg::COORD_W;
    localparam int DW   = nnta_pkg::DIST_W;
    localparam int SW   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNTW = $clog2(MAX_TRACKS + 1);
    localparam int CW   = $clog2(HIST_DEPTH + 1);
    localparam int TW   = CW + 2 * CRW;
    localparam int HAW  = $clog2(MAX_TRACKS * HIST_DEPTH);
    localparam int SWX  = (SW > nnta_pkg::TIDX_W) ? SW : nnta_pkg::TIDX_W;
    localparam int CWX  = (CW > nnta_pkg::HLEN_W) ? CW : nnta_pkg::HLEN_W;

    nnta_pkg::ctrl_state_t  state_reg, state_next;
    logic [DW-1:0]          thr_reg;
    logic [MAX_TRACKS-1:0]  active_reg, active_next;
    logic [MAX_TRACKS-1:0]  matched_reg, matched_next;
    logic [CNTW-1:0]        issue_cnt_reg, issue_cnt_next;
    logic                   iss_v_reg, iss_v_next;
    logic                   iss_cand_reg, iss_cand_next;
    logic [SW-1:0]          iss_idx_reg;

    logic [CRW-1:0]         det_x_reg;
    logic [CRW-1:0]         det_y_reg;
    logic                   last_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [nnta_pkg::TIDX_W-1:0]    out_idx_reg;
    logic [nnta_pkg::OUTCOME_W-1:0] out_outcome_reg;
    logic [nnta_pkg::HLEN_W-1:0]    out_hlen_reg;
    logic                   out_last_reg;

    logic                   scan_start;
    logic                   rd_en;
    logic [SW-1:0]          rd_addr;
    logic [TW-1:0]          rd_data;
    logic                   trk_wr_en;
    logic                   hist_wr_en;
    logic [HAW-1:0]         hist_wr_addr;

    nnta_pkg::scan_status_t scan_status;
    logic [SW-1:0]          best_idx;
    logic [CW-1:0]          best_cnt;

    logic                   match;
    logic                   free_any;
    logic [SW-1:0]          free_idx;
    logic [SW-1:0]          slot;
    logic [CW-1:0]          new_cnt;
    logic [CW-1:0]          hcnt;
    logic                   hist_room;
    logic [nnta_pkg::OUTCOME_W-1:0] outcome;
    logic [CW-1:0]          hlen;
    logic [SWX-1:0]         slot_ext;
    logic [CWX-1:0]         hlen_ext;
    logic                   out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= nnta_pkg::THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // decision on the swept result
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int j = MAX_TRACKS - 1; j >= 0; j--)
        begin
            if (!active_reg[j])
            begin
                free_any = 1'b1;
                free_idx = SW'(j);
            end
        end
        match     = scan_status.found && (scan_status.best_dist < thr_reg);
        hist_room = best_cnt < CW'(HIST_DEPTH);
        new_cnt   = hist_room ? best_cnt + CW'(1) : best_cnt;
        if (match)
        begin
            slot    = best_idx;
            outcome = nnta_pkg::OUTCOME_MATCH;
            hlen    = new_cnt;
            hcnt    = best_cnt;
        end
        else if (free_any)
        begin
            slot    = free_idx;
            outcome = nnta_pkg::OUTCOME_NEW;
            hlen    = CW'(1);
            hcnt    = '0;
        end
        else
        begin
            slot    = '0;
            outcome = nnta_pkg::OUTCOME_DROP;
            hlen    = '0;
            hcnt    = '0;
        end
        hist_wr_addr = HAW'(HAW'(slot) * HAW'(HIST_DEPTH) + HAW'(hcnt));
        slot_ext     = SWX'(slot);
        hlen_ext     = CWX'(hlen);
    end

    always_comb
    begin
        state_next     = state_reg;
        issue_cnt_next = issue_cnt_reg;
        active_next    = active_reg;
        matched_next   = matched_reg;
        out_valid_next = out_valid_reg && !m_tready;
        iss_v_next     = 1'b0;
        iss_cand_next  = 1'b0;
        s_tready       = 1'b0;
        scan_start     = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = issue_cnt_reg[SW-1:0];
        trk_wr_en      = 1'b0;
        hist_wr_en     = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            nnta_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next     = nnta_pkg::ST_SCAN;
                    issue_cnt_next = '0;
                    scan_start     = 1'b1;
                end
            end
            nnta_pkg::ST_SCAN:
            begin
                if (issue_cnt_reg != CNTW'(MAX_TRACKS))
                begin
                    rd_en          = 1'b1;
                    iss_v_next     = 1'b1;
                    iss_cand_next  = active_reg[rd_addr] && !matched_reg[rd_addr];
                    issue_cnt_next = issue_cnt_reg + CNTW'(1);
                end
                else if (!iss_v_reg && !scan_status.busy)
                begin
                    state_next = nnta_pkg::ST_DECIDE;
                end
            end
            nnta_pkg::ST_DECIDE:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = nnta_pkg::ST_IDLE;
                    if (match)
                    begin
                        trk_wr_en          = 1'b1;
                        hist_wr_en         = hist_room;
                        matched_next[slot] = 1'b1;
                    end
                    else if (free_any)
                    begin
                        trk_wr_en          = 1'b1;
                        hist_wr_en         = 1'b1;
                        active_next[slot]  = 1'b1;
                        matched_next[slot] = 1'b1;
                    end
                    if (last_reg)
                    begin
                        active_next  = active_next & matched_next;
                        matched_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = nnta_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nnta_pkg::ST_IDLE;
            active_reg    <= '0;
            matched_reg   <= '0;
            issue_cnt_reg <= '0;
            iss_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            matched_reg   <= matched_next;
            issue_cnt_reg <= issue_cnt_next;
            iss_v_reg     <= iss_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_cand_reg <= iss_cand_next;
        iss_idx_reg  <= rd_addr;
        if (s_tvalid && s_tready)
        begin
            det_x_reg <= s_tdata[CRW-1:0];
            det_y_reg <= s_tdata[2*CRW-1:CRW];
            last_reg  <= s_tlast;
        end
        if (out_load)
        begin
            out_idx_reg     <= slot_ext[nnta_pkg::TIDX_W-1:0];
            out_outcome_reg <= outcome;
            out_hlen_reg    <= hlen_ext[nnta_pkg::HLEN_W-1:0];
            out_last_reg    <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_hlen_reg, out_outcome_reg, out_idx_reg};
    assign m_tlast  = out_last_reg;

    // writes happen only in the decide cycle, never alongside a sweep read
    nnta_track_mem #(
        .DEPTH (MAX_TRACKS),
        .WIDTH (TW),
        .AW    (SW)
    ) u_track_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (trk_wr_en),
        .wr_addr (slot),
        .wr_data ({(match ? new_cnt : CW'(1)), det_y_reg, det_x_reg})
    );

    nnta_hist_mem #(
        .DEPTH (MAX_TRACKS * HIST_DEPTH),
        .AW    (HAW)
    ) u_hist_mem (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data ({det_y_reg, det_x_reg})
    );

    nnta_dist_unit #(
        .SW (SW),
        .CW (CW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .det_x     (det_x_reg),
        .det_y     (det_y_reg),
        .ent_valid (iss_v_reg),
        .ent_cand  (iss_cand_reg),
        .ent_idx   (iss_idx_reg),
        .ent_data  (rd_data),
        .status    (scan_status),
        .best_idx  (best_idx),
        .best_cnt  (best_cnt)
    );

    a_matched_subset: assert property (@(posedge clk) disable iff (!rst_n)
        (matched_reg & ~active_reg) == '0)
        else $error("matched slot not active");

    a_match_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnta_pkg::ST_DECIDE && out_free && match && !last_reg)
        |=> matched_reg[$past(best_idx)])
        else $error("matched track not marked");

    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == nnta_pkg::ST_DECIDE))
        else $error("result without decision");

    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnta_pkg::ST_SCAN)
        |=> (state_reg == nnta_pkg::ST_SCAN || state_reg == nnta_pkg::ST_DECIDE))
        else $error("bad exit from scan");

    a_pick_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nnta_pkg::ST_DECIDE && match)
        |-> (active_reg[best_idx] && !matched_reg[best_idx]))
        else $error("best track was not a candidate");

endmodule

// ----- rtl/core/nnta_track_mem.sv -----
module nnta_track_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 29,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/nnta_hist_mem.sv -----
module nnta_hist_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [2*nnta_pkg::COORD_W-1:0] wr_data
);

    // point history, y in the upper half; readout port not brought out
    logic [2*nnta_pkg::COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ----- rtl/core/nnta_dist_unit.sv -----
module nnta_dist_unit #(
    parameter int SW = 4,
    parameter int CW = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [nnta_pkg::COORD_W-1:0]     det_x,
    input  logic [nnta_pkg::COORD_W-1:0]     det_y,
    input  logic                             ent_valid,
    input  logic                             ent_cand,
    input  logic [SW-1:0]                    ent_idx,
    input  logic [CW+2*nnta_pkg::COORD_W-1:0] ent_data,
    output nnta_pkg::scan_status_t           status,
    output logic [SW-1:0]                    best_idx,
    output logic [CW-1:0]                    best_cnt
);

    localparam int CRW = nnta_pkg::COORD_W;
    localparam int DW  = nnta_pkg::DIST_W;

    logic [CRW-1:0]   px;
    logic [CRW-1:0]   py;
    logic [CRW-1:0]   dx;
    logic [CRW-1:0]   dy;

    logic             s1_v_reg;
    logic             s1_cand_reg;
    logic [SW-1:0]    s1_idx_reg;
    logic [CW-1:0]    s1_cnt_reg;
    logic [2*CRW-1:0] sq_x_reg;
    logic [2*CRW-1:0] sq_y_reg;

    logic             s2_v_reg;
    logic             s2_cand_reg;
    logic [SW-1:0]    s2_idx_reg;
    logic [CW-1:0]    s2_cnt_reg;
    logic [DW-1:0]    sum_reg;

    logic             found_reg;
    logic [DW-1:0]    best_dist_reg;
    logic [SW-1:0]    best_idx_reg;
    logic [CW-1:0]    best_cnt_reg;
    logic             take;

    assign px = ent_data[CRW-1:0];
    assign py = ent_data[2*CRW-1:CRW];
    assign dx = (det_x > px) ? det_x - px : px - det_x;
    assign dy = (det_y > py) ? det_y - py : py - det_y;

    // first minimum wins: strict compare
    assign take = s2_v_reg && s2_cand_reg && (!found_reg || sum_reg < best_dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= ent_valid;
            s2_v_reg <= s1_v_reg;
            if (start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cand_reg <= ent_cand;
        s1_idx_reg  <= ent_idx;
        s1_cnt_reg  <= ent_data[CW+2*CRW-1:2*CRW];
        sq_x_reg    <= dx * dx;
        sq_y_reg    <= dy * dy;
        s2_cand_reg <= s1_cand_reg;
        s2_idx_reg  <= s1_idx_reg;
        s2_cnt_reg  <= s1_cnt_reg;
        sum_reg     <= DW'(sq_x_reg) + DW'(sq_y_reg);
        if (take)
        begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= s2_idx_reg;
            best_cnt_reg  <= s2_cnt_reg;
        end
    end

    assign status.busy      = s1_v_reg | s2_v_reg;
    assign status.found     = found_reg;
    assign status.best_dist = best_dist_reg;
    assign best_idx         = best_idx_reg;
    assign best_cnt         = best_cnt_reg;

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = nnta_pkg::COORD_W;
    localparam int DIST_W    = nnta_pkg::DIST_W;
    localparam int TIDX_W    = nnta_pkg::TIDX_W;
    localparam int OUTCOME_W = nnta_pkg::OUTCOME_W;
    localparam int HLEN_W    = nnta_pkg::HLEN_W;

    localparam int MAX_TRACKS    = 16;
    localparam int HIST_DEPTH    = 16;
    localparam int COORD_MAX     = 4095;
    localparam int SETTLE_CYCLES = 30;
    localparam int STALL_LIMIT   = 4000;
    localparam int DIR_ROWS      = 25;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 140;
    localparam logic [DIST_W-1:0] THR_MAX = 25'd33538050;

    typedef struct packed {
        logic [TIDX_W-1:0]    idx;
        logic [OUTCOME_W-1:0] outcome;
        logic [HLEN_W-1:0]    hlen;
        logic                 done;
    } track_result_t;

    typedef struct packed {
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic                 last;
        logic                 typed;
        logic [TIDX_W-1:0]    idx;
        logic [OUTCOME_W-1:0] outcome;
        logic [HLEN_W-1:0]    hlen;
    } detection_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // det_x[11:0], det_y[23:12]
    logic        s_tlast = 1'b0;   // last_in_frame
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // track_index[3:0], outcome[5:4], history_length[10:6]
    logic        m_tlast;          // frame_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [24:0] cfg_data = '0;    // dist_sq_threshold

    nearest_neighbor_track_associator #(
        .MAX_TRACKS(MAX_TRACKS),
        .HIST_DEPTH(HIST_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // track table mirror
    logic [DIST_W-1:0]     dist_thr = nnta_pkg::THR_RESET;
    logic [COORD_W-1:0]    trk_x [MAX_TRACKS];
    logic [COORD_W-1:0]    trk_y [MAX_TRACKS];
    logic [MAX_TRACKS-1:0] trk_active = '0;
    logic [MAX_TRACKS-1:0] trk_matched = '0;
    logic [HLEN_W-1:0]     trk_hist [MAX_TRACKS];

    track_result_t pending_results [$];

    int  n_err = 0;
    int  n_det = 0;
    int  n_frames = 0;
    int  n_match = 0;
    int  n_new = 0;
    int  n_drop = 0;
    int  n_full = 0;
    int  n_cfg = 0;
    int  idle_cycles = 0;
    bit  src_quiet = 1'b0;
    bit  sink_quiet = 1'b0;

    detection_row_t dir_rows [DIR_ROWS] = '{
        '{12'd0,    12'd0,    1'b0, 1'b1, 4'd0, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd4095, 12'd4095, 1'b1, 1'b1, 4'd1, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd10,   12'd10,   1'b0, 1'b1, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd2},
        '{12'd4095, 12'd4095, 1'b0, 1'b1, 4'd1, nnta_pkg::OUTCOME_MATCH, 5'd2},
        '{12'd4000, 12'd4000, 1'b1, 1'b1, 4'd2, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0},
        '{12'd10,   12'd10,   1'b1, 1'b1, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd16},
        '{12'd10,   12'd10,   1'b1, 1'b1, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd16},
        '{12'd4095, 12'd0,    1'b0, 1'b1, 4'd1, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd0,    12'd4095, 1'b0, 1'b1, 4'd2, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd0,    12'd0,    1'b1, 1'b1, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd16},
        '{12'd50,   12'd0,    1'b0, 1'b1, 4'd3, nnta_pkg::OUTCOME_NEW,   5'd1},
        '{12'd2047, 12'd2047, 1'b1, 1'b0, 4'd0, nnta_pkg::OUTCOME_MATCH, 5'd0}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic track_result_t associate(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic last);
        track_result_t r;
        logic          found;
        int            best;
        int unsigned   best_d;
        int unsigned   dx;
        int unsigned   dy;
        int unsigned   d;
        int            j;
        r = '{idx: '0, outcome: nnta_pkg::OUTCOME_DROP, hlen: '0, done: last};
        found = 1'b0;
        best = 0;
        best_d = 0;
        for (j = 0; j < MAX_TRACKS; j++)
        begin
            if (trk_active[j] && !trk_matched[j])
            begin
                dx = (x > trk_x[j]) ? x - trk_x[j] : trk_x[j] - x;
                dy = (y > trk_y[j]) ? y - trk_y[j] : trk_y[j] - y;
                d = dx * dx + dy * dy;
                if (!found || d < best_d)
                begin
                    found = 1'b1;
                    best_d = d;
                    best = j;
                end
            end
        end
        if (found && best_d < dist_thr)
        begin
            trk_x[best] = x;
            trk_y[best] = y;
            if (trk_hist[best] < HIST_DEPTH)
                trk_hist[best] = trk_hist[best] + 1'b1;
            else
                n_full++;
            trk_matched[best] = 1'b1;
            r.idx = best[TIDX_W-1:0];
            r.outcome = nnta_pkg::OUTCOME_MATCH;
            r.hlen = trk_hist[best];
        end
        else
        begin
            for (j = 0; j < MAX_TRACKS; j++)
            begin
                if (!trk_active[j] && r.outcome == nnta_pkg::OUTCOME_DROP)
                begin
                    trk_active[j] = 1'b1;
                    trk_matched[j] = 1'b1;
                    trk_x[j] = x;
                    trk_y[j] = y;
                    trk_hist[j] = 5'd1;
                    r.idx = j[TIDX_W-1:0];
                    r.outcome = nnta_pkg::OUTCOME_NEW;
                    r.hlen = 5'd1;
                end
            end
        end
        if (last)
        begin
            trk_active = trk_active & trk_matched;
            trk_matched = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        n_err++;
    endtask

    task automatic send_detection(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                  input logic last, input logic typed,
                                  input track_result_t typed_result);
        int            gap;
        track_result_t predicted;
        gap = src_quiet ? 0 : int'($urandom_range(0, 8));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        predicted = associate(x, y, last);
        pending_results.push_back(typed ? typed_result : predicted);
        n_det++;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [DIST_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        dist_thr = value;
        n_cfg++;
    endtask

    function automatic logic [COORD_W-1:0] clamp_coord(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
        return v[COORD_W-1:0];
    endfunction

    task automatic run_random_frames(input int items);
        int            left;
        int            flen;
        int            kind;
        int            jit;
        int            k;
        int            j;
        int            base_x;
        int            base_y;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic          last;
        track_result_t none;
        none = '0;
        left = items;
        while (left > 0)
        begin
            flen = int'($urandom_range(1, 20));
            kind = int'($urandom_range(0, 9));
            case ($urandom_range(0, 2))
                0: jit = 3;
                1: jit = 40;
                default: jit = 80;
            endcase
            case ($urandom_range(0, 2))
                0:
                begin
                    base_x = 0;
                    base_y = 0;
                end
                1:
                begin
                    base_x = COORD_MAX - 7;
                    base_y = COORD_MAX - 7;
                end
                default:
                begin
                    base_x = int'($urandom_range(0, COORD_MAX - 7));
                    base_y = int'($urandom_range(0, COORD_MAX - 7));
                end
            endcase
            src_quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < flen && left > 0; k++)
            begin
                if (kind <= 5 && trk_active != '0 && $urandom_range(0, 3) != 0)
                begin
                    // follow an existing track with some jitter
                    do j = int'($urandom_range(0, MAX_TRACKS - 1)); while (!trk_active[j]);
                    x = clamp_coord(int'(trk_x[j]) + int'($urandom_range(0, 2 * jit)) - jit);
                    y = clamp_coord(int'(trk_y[j]) + int'($urandom_range(0, 2 * jit)) - jit);
                end
                else if (kind <= 7)
                begin
                    // tight cluster: equal distances and exact threshold hits
                    x = clamp_coord(base_x + int'($urandom_range(0, 7)));
                    y = clamp_coord(base_y + int'($urandom_range(0, 7)));
                end
                else
                begin
                    x = COORD_W'($urandom_range(0, COORD_MAX));
                    y = COORD_W'($urandom_range(0, COORD_MAX));
                end
                last = (k == flen - 1);
                if ($urandom_range(0, 24) == 0)
                    last = ~last;
                send_detection(x, y, last, 1'b0, none);
                left--;
            end
        end
    endtask

    initial
    begin
        logic [DIST_W-1:0] phase_thr [PHASES];
        track_result_t     typed_result;
        int                r;
        int                p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            typed_result = '{idx: dir_rows[r].idx, outcome: dir_rows[r].outcome,
                             hlen: dir_rows[r].hlen, done: dir_rows[r].last};
            send_detection(dir_rows[r].x, dir_rows[r].y, dir_rows[r].last,
                           dir_rows[r].typed, typed_result);
        end
        s_tvalid <= 1'b0;

        phase_thr[0] = '0;
        phase_thr[1] = 25'd1;
        phase_thr[2] = THR_MAX;
        phase_thr[3] = nnta_pkg::THR_RESET;
        phase_thr[4] = 25'd5;
        phase_thr[5] = DIST_W'($urandom_range(2, 200000));
        phase_thr[6] = THR_MAX - 1'b1;
        phase_thr[7] = DIST_W'($urandom_range(0, 32'(THR_MAX)));
        for (p = 0; p < PHASES; p++)
        begin
            set_threshold(phase_thr[p]);
            run_random_frames(PHASE_ITEMS);
            s_tvalid <= 1'b0;
        end

        wait_idle();
        $display("%0d detections in %0d frames, %0d threshold writes, %0d mismatches",
                 n_det, n_frames, n_cfg, n_err);
        $display("outcomes: %0d matched (%0d at full history), %0d new tracks, %0d dropped",
                 n_match, n_full, n_new, n_drop);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        track_result_t want;
        int            w;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                sink_quiet = ~sink_quiet;
            w = sink_quiet ? 0 : int'($urandom_range(0, 8));
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, none pending", int'(m_tdata), 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[3:0] != want.idx)
                    report_mismatch("track_index", int'(m_tdata[3:0]), int'(want.idx));
                if (m_tdata[5:4] != want.outcome)
                    report_mismatch("outcome", int'(m_tdata[5:4]), int'(want.outcome));
                if (m_tdata[10:6] != want.hlen)
                    report_mismatch("history_length", int'(m_tdata[10:6]), int'(want.hlen));
                if (m_tlast != want.done)
                    report_mismatch("frame_done", int'(m_tlast), int'(want.done));
                case (want.outcome)
                    nnta_pkg::OUTCOME_MATCH: n_match++;
                    nnta_pkg::OUTCOME_NEW:   n_new++;
                    default:                 n_drop++;
                endcase
                if (want.done)
                    n_frames++;
            end
        end
    end

    // stall watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
